>>> rtl/core/time_of_day_clock_with_scan_display_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the time-of-day clock
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_CLOCK_WITH_SCAN_DISPLAY_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_SCAN_DISPLAY_DEFINES_SVH

`ifndef SYNTHESIS
// overlapping implication, checked out of reset
`define TOD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tod assertion failed");
// implication on the next clock edge
`define TOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tod assertion failed");
`else
`define TOD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/tod_pkg.sv
// ----------------------------------------------------------------------------
// tod_pkg
// Shared types, constants and helper functions of the time-of-day clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_SET  = 2'd1,
        CMD_ADD  = 2'd2,
        CMD_GET  = 2'd3
    } t_tod_cmd;

    localparam logic [6:0] COUNT_MAX   = 7'd127;
    localparam logic [6:0] SEC_LIMIT   = 7'd60;
    localparam logic [6:0] MIN_LIMIT   = 7'd60;
    localparam logic [6:0] HOUR_LIMIT  = 7'd24;
    localparam logic [6:0] RESET_HOURS = 7'd10;
    localparam logic [6:0] RESET_MINS  = 7'd58;
    localparam logic [6:0] RESET_SECS  = 7'd58;
    localparam logic [7:0] SEG_DASH    = 8'h40;
    localparam logic [2:0] POS_DASH_HI = 3'd2;
    localparam logic [2:0] POS_DASH_LO = 3'd5;

    // input transaction
    typedef struct packed {
        logic       second_tick;
        logic       repeat_tick;
        logic       sec_button_down;
        logic       min_button_down;
        logic [1:0] command;
        logic [6:0] cmd_hours;
        logic [6:0] cmd_minutes;
        logic [6:0] cmd_seconds;
    } t_tod_in;

    // result transaction
    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] digit_select;
        logic [6:0] hours_now;
        logic [6:0] minutes_now;
        logic [6:0] seconds_now;
        logic       command_done;
    } t_tod_out;

    // time value passed between the counter and the scan logic
    typedef struct packed {
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } t_tod_time;

    // 7-bit add that saturates at COUNT_MAX
    function automatic logic [6:0] sat_add(input logic [6:0] a, input logic [6:0] b);
        logic [7:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[7] ? COUNT_MAX : sum[6:0];
    endfunction

    // tens digit of a 7-bit value (0..12), reciprocal multiply
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod = {8'd0, v} * 15'd205;
        return prod[14:11];
    endfunction

    // seven-segment pattern, codes above nine show the letter A pattern (8'h77)
    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] pat;
        unique case (d)
            4'd0:    pat = 8'h3f;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5b;
            4'd3:    pat = 8'h4f;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6d;
            4'd6:    pat = 8'h7d;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7f;
            4'd9:    pat = 8'h6f;
            default: pat = 8'h77;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/time_of_day_clock_with_scan_display.sv
// ----------------------------------------------------------------------------
// time_of_day_clock_with_scan_display
// Hours/minutes/seconds clock with an eight-position scanned display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, i_data) carries one control-loop pass:
//   ticks, button levels and an optional set/add/get command.
//   Output channel (o_valid / i_ready, o_data) returns one transaction per
//   pass: segment pattern and one-hot select of the scanned position, the
//   stored time after the pass and a command-done flag.
//   Path: an accepted transaction goes through the input register, then
//   the result register, from which the receiver takes it on o_data.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the time update, the decimal digit ripple and the segment decode all
//   sit in one stage between the input and result registers.
//   Reset (synchronous, active low): time 10:58:58, buttons released, scan
//   at position 0, both pipeline registers empty.
//   Receiver stall: the result register holds; the input register still
//   takes one more transaction, after which o_ready drops until i_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "time_of_day_clock_with_scan_display_defines.svh"

module time_of_day_clock_with_scan_display (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  tod_pkg::t_tod_in     i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output tod_pkg::t_tod_out    o_data
);
    import tod_pkg::*;

    t_tod_in    r_in;
    logic       r_in_valid;
    t_tod_out   r_out;
    logic       r_out_valid;
    logic       adv;
    logic       step;
    logic       in_take;
    t_tod_time  time_cur;
    t_tod_time  time_next;
    logic [7:0] segments;
    logic [7:0] digit_select;
    logic       chk_dash;
    logic       chk_plain;
    logic       chk_range;

    // flow control
    assign adv     = !r_out_valid || i_ready;
    assign step    = r_in_valid && adv;
    assign o_ready = !r_in_valid || adv;
    assign in_take = i_valid && o_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_data;
        end
    end

    tod_time u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_item  (r_in),
        .o_cur   (time_cur),
        .o_next  (time_next)
    );

    tod_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (step),
        .i_time         (time_cur),
        .o_segments     (segments),
        .o_digit_select (digit_select)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.segments     <= segments;
            r_out.digit_select <= digit_select;
            r_out.hours_now    <= time_next.hours;
            r_out.minutes_now  <= time_next.minutes;
            r_out.seconds_now  <= time_next.seconds;
            r_out.command_done <= (r_in.command != CMD_NONE);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    assign chk_dash  = r_out_valid && (r_out.digit_select[2] || r_out.digit_select[5]);
    assign chk_plain = r_out_valid && !r_out.command_done;
    assign chk_range = (r_out.hours_now < HOUR_LIMIT) && (r_out.minutes_now < MIN_LIMIT)
                       && (r_out.seconds_now < SEC_LIMIT);

    `TOD_ASSERT_IMPL(a_dash_pos, i_clk, i_rst_n, chk_dash, r_out.segments == SEG_DASH)
    `TOD_ASSERT_IMPL(a_time_range, i_clk, i_rst_n, chk_plain, chk_range)
    `TOD_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_ready, r_in_valid && r_out_valid)
    `TOD_ASSERT_NEXT(a_step_result, i_clk, i_rst_n, step, r_out_valid)

endmodule

`default_nettype wire

>>> rtl/core/tod_time.sv
// ----------------------------------------------------------------------------
// tod_time
// Time counters and button state; one update per executed transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tod_time (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  tod_pkg::t_tod_in     i_item,
    output tod_pkg::t_tod_time   o_cur,
    output tod_pkg::t_tod_time   o_next
);
    import tod_pkg::*;

    logic [6:0] r_hours, r_mins, r_secs;
    logic       r_sec_held, r_min_held;
    logic [6:0] n_hours, n_mins, n_secs;
    logic       n_sec_held, n_min_held;

    // one pass: ticks, buttons, wraps, then command
    always_comb begin
        n_hours    = r_hours;
        n_mins     = r_mins;
        n_secs     = r_secs;
        n_sec_held = i_item.sec_button_down;
        n_min_held = i_item.min_button_down;

        // second tick is ignored while a button is held
        if (i_item.second_tick && !r_sec_held && !r_min_held) begin
            n_secs = sat_add(n_secs, 7'd1);
        end
        // auto-repeat
        if (i_item.repeat_tick) begin
            if (r_sec_held) begin
                n_secs = sat_add(n_secs, 7'd1);
            end
            if (r_min_held) begin
                n_mins = sat_add(n_mins, 7'd1);
            end
        end
        // release adds one more step
        if (!i_item.sec_button_down && r_sec_held) begin
            n_secs = sat_add(n_secs, 7'd1);
        end
        if (!i_item.min_button_down && r_min_held) begin
            n_mins = sat_add(n_mins, 7'd1);
        end

        // wraps with carry
        if (n_secs >= SEC_LIMIT) begin
            n_mins = sat_add(n_mins, 7'd1);
            n_secs = '0;
        end
        if (n_mins >= MIN_LIMIT) begin
            n_hours = sat_add(n_hours, 7'd1);
            n_mins  = '0;
        end
        if (n_hours >= HOUR_LIMIT) begin
            n_hours = '0;
        end

        // host commands
        unique case (i_item.command)
            CMD_SET: begin
                n_hours = i_item.cmd_hours;
                n_mins  = i_item.cmd_minutes;
                n_secs  = i_item.cmd_seconds;
            end
            CMD_ADD: begin
                n_hours = sat_add(n_hours, i_item.cmd_hours);
                n_mins  = sat_add(n_mins, i_item.cmd_minutes);
                n_secs  = sat_add(n_secs, i_item.cmd_seconds);
            end
            CMD_NONE, CMD_GET: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours    <= RESET_HOURS;
            r_mins     <= RESET_MINS;
            r_secs     <= RESET_SECS;
            r_sec_held <= 1'b0;
            r_min_held <= 1'b0;
        end else if (i_en) begin
            r_hours    <= n_hours;
            r_mins     <= n_mins;
            r_secs     <= n_secs;
            r_sec_held <= n_sec_held;
            r_min_held <= n_min_held;
        end
    end

    assign o_cur  = '{hours: r_hours, minutes: r_mins, seconds: r_secs};
    assign o_next = '{hours: n_hours, minutes: n_mins, seconds: n_secs};

endmodule

`default_nettype wire

>>> rtl/core/tod_scan.sv
// ----------------------------------------------------------------------------
// tod_scan
// Display scan: position counter, time snapshot and digit/segment decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tod_scan (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  tod_pkg::t_tod_time   i_time,
    output logic [7:0]           o_segments,
    output logic [7:0]           o_digit_select
);
    import tod_pkg::*;

    logic [2:0] r_pos;
    t_tod_time  r_snap;
    t_tod_time  snap;
    logic [3:0] h1, h0, m1, m0, s1, s0;
    logic [3:0] t1, t2, t3, t4, t5;
    logic [3:0] d1, d2, d3, d4;
    logic       c1, c2, c3, c4;
    logic [3:0] digit;

    // snapshot is refreshed at position 0 and used in the same pass
    assign snap = (r_pos == 3'd0) ? i_time : r_snap;

    // split each field into two decimal digits
    always_comb begin
        h1 = tens_of(snap.hours);
        m1 = tens_of(snap.minutes);
        s1 = tens_of(snap.seconds);
        h0 = 4'(snap.hours   - ({3'd0, h1} * 7'd10));
        m0 = 4'(snap.minutes - ({3'd0, m1} * 7'd10));
        s0 = 4'(snap.seconds - ({3'd0, s1} * 7'd10));
    end

    // decimal carry ripple of h*10000 + m*100 + s
    always_comb begin
        t1 = s1;
        c1 = (t1 >= 4'd10);
        d1 = c1 ? t1 - 4'd10 : t1;
        t2 = m0 + {3'd0, c1};
        c2 = (t2 >= 4'd10);
        d2 = c2 ? t2 - 4'd10 : t2;
        t3 = m1 + {3'd0, c2};
        c3 = (t3 >= 4'd10);
        d3 = c3 ? t3 - 4'd10 : t3;
        t4 = h0 + {3'd0, c3};
        c4 = (t4 >= 4'd10);
        d4 = c4 ? t4 - 4'd10 : t4;
        t5 = h1 + {3'd0, c4};
    end

    // digit for the scan position; leading digit is not reduced
    always_comb begin
        unique case (r_pos)
            3'd0:    digit = t5;
            3'd1:    digit = d4;
            3'd3:    digit = d3;
            3'd4:    digit = d2;
            3'd6:    digit = d1;
            default: digit = s0;
        endcase
    end

    assign o_segments     = (r_pos == POS_DASH_HI || r_pos == POS_DASH_LO)
                            ? SEG_DASH : seg_pattern(digit);
    assign o_digit_select = 8'd1 << r_pos;

    // scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_en) begin
            r_pos <= r_pos + 3'd1;
        end
    end

    // snapshot, no reset: written at position 0 before any read
    always_ff @(posedge i_clk) begin
        if (i_en && r_pos == 3'd0) begin
            r_snap <= i_time;
        end
    end

endmodule

`default_nettype wire
